// File: sv/soc_pkg.sv
// soc_pkg: shared widths, defaults and the cell control struct for the
// subarray occurrence counter; no dependencies
package soc_pkg;

    // field widths fixed by the stream format
    localparam int WORD_W  = 32;
    localparam int PIDX_W  = 6;
    localparam int LEN_W   = 7;
    localparam int COUNT_W = 13;

    // packed bus widths, whole bytes
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 16;

    // defaults for the top-level parameters
    localparam int DEF_MAX_PATTERN = 64;
    localparam int DEF_MAX_COUNT   = 4096;

    // command codes carried on the input tuser bit
    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_TEXT = 1'b1
    } soc_cmd_t;

    // control broadcast to every cell of the chain
    typedef struct packed {
        logic              load_en;
        logic              text_en;
        logic              clear;
        logic [PIDX_W-1:0] load_index;
    } soc_ctrl_t;

endpackage

// File: sv/subarray_occurrence_counter.sv
// subarray_occurrence_counter: top level, chain of pattern cells, counter and
// output register; depends on soc_pkg, soc_cell, soc_counter
//
// channel   dir  handshake            payload
// s_*       in   s_tvalid/s_tready    tdata: word_value[31:0] pattern_index[37:32]
//                                     tuser: command, tlast: text_last
// m_*       out  m_tvalid/m_tready    tdata: match_here[0] occurrence_count[13:1]
//                                     tlast: stream_done
// cfg_*     in   cfg_we               cfg_wdata: pattern_length
//
// one transfer per cycle unless the output stalls; a text word's result is in the
// output register the cycle after its transfer, set by one compare in every cell
// plus the flag select and the count increment
// a load transfer gives no result
// reset clears prefix flags, count, output valid and sets pattern_length to 1
// input is taken while the output register is empty or being drained
module subarray_occurrence_counter #(
    parameter int MAX_PATTERN = soc_pkg::DEF_MAX_PATTERN,
    parameter int MAX_COUNT   = soc_pkg::DEF_MAX_COUNT
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // word_value [31:0], pattern_index [37:32], zero [39:38]
    input  logic [soc_pkg::S_DATA_W-1:0] s_tdata,
    // command [0]
    input  logic                         s_tuser,
    input  logic                         s_tlast,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // match_here [0], occurrence_count [13:1], zero [15:14]
    output logic [soc_pkg::M_DATA_W-1:0] m_tdata,
    output logic                         m_tlast,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    input  logic                         cfg_we,
    input  logic [soc_pkg::LEN_W-1:0]    cfg_wdata
);
    import soc_pkg::*;

    localparam int IW    = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int LW    = ($clog2(MAX_PATTERN + 1) > LEN_W) ? $clog2(MAX_PATTERN + 1) : LEN_W;
    localparam int CNT_W = (MAX_COUNT > 1) ? $clog2(MAX_COUNT + 1) : 1;

    logic                   s_fire;
    soc_ctrl_t              ctrl;
    logic [WORD_W-1:0]      word;
    logic [LEN_W-1:0]       pattern_length_reg;
    logic [LW-1:0]          len_ext;
    logic [LW-1:0]          len_eff;
    logic [IW-1:0]          len_sel;
    logic [MAX_PATTERN:0]   chain_flag;
    logic [MAX_PATTERN-1:0] flags_next;
    logic                   match;
    logic [CNT_W-1:0]       count_next;
    logic [CNT_W-1:0]       count_value;

    logic                   m_valid_reg;
    logic                   m_match_reg;
    logic [COUNT_W-1:0]     m_count_reg;
    logic                   m_last_reg;

    // input transfer and the control broadcast to the chain
    assign s_tready = !m_valid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;
    assign word     = s_tdata[WORD_W-1:0];

    always_comb begin
        ctrl.load_en    = s_fire && (soc_cmd_t'(s_tuser) == CMD_LOAD);
        ctrl.text_en    = s_fire && (soc_cmd_t'(s_tuser) == CMD_TEXT);
        ctrl.clear      = s_tlast;
        ctrl.load_index = s_tdata[WORD_W +: PIDX_W];
    end

    // pattern length register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_length_reg <= LEN_W'(1);
        end else if (cfg_we) begin
            pattern_length_reg <= cfg_wdata;
        end
    end

    // clamp length to 1..MAX_PATTERN and pick the last position
    always_comb begin
        len_ext = LW'(pattern_length_reg);
        if (len_ext == '0) begin
            len_eff = LW'(1);
        end else if (len_ext > LW'(MAX_PATTERN)) begin
            len_eff = LW'(MAX_PATTERN);
        end else begin
            len_eff = len_ext;
        end
        len_sel = IW'(len_eff - LW'(1));
    end

    // the cell chain, position 0 always sees a held prefix
    assign chain_flag[0] = 1'b1;

    for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
        soc_cell #(
            .IDX (j)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (ctrl),
            .word      (word),
            .flag_in   (chain_flag[j]),
            .flag_out  (chain_flag[j+1]),
            .flag_next (flags_next[j])
        );
    end

    assign match = ctrl.text_en && flags_next[len_sel];

    // occurrence count
    soc_counter #(
        .MAX_COUNT (MAX_COUNT)
    ) u_counter (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (ctrl),
        .match       (match),
        .count_next  (count_next),
        .count_value (count_value)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_tready) begin
            m_valid_reg <= ctrl.text_en;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.text_en) begin
            m_match_reg <= match;
            m_count_reg <= COUNT_W'(count_next);
            m_last_reg  <= s_tlast;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {{(M_DATA_W - COUNT_W - 1){1'b0}}, m_count_reg, m_match_reg};

    // count never passes its bound
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_value <= CNT_W'(MAX_COUNT))
        else $error("occurrence count above bound");

    // a pattern load never creates a result
    a_load_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.load_en |=> !m_tvalid)
        else $error("result after pattern load");

    // the last text word leaves the count and prefix flags cleared
    a_stream_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.text_en && s_tlast) |=>
            (count_value == '0) && (chain_flag[MAX_PATTERN:1] == '0))
        else $error("state not cleared after end of stream");

endmodule

// File: sv/soc_cell.sv
// soc_cell: one position of the pattern chain, holds a pattern word and its
// prefix flag; depends on soc_pkg
module soc_cell #(
    parameter int IDX = 0
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  soc_pkg::soc_ctrl_t        ctrl,
    input  logic [soc_pkg::WORD_W-1:0] word,
    input  logic                      flag_in,
    output logic                      flag_out,
    output logic                      flag_next
);
    import soc_pkg::*;

    logic [WORD_W-1:0] pat_reg;
    logic              flag_reg;
    logic              hit;

    // pattern word load, addressed by the cell position
    always_ff @(posedge aclk) begin
        if (ctrl.load_en && (32'(ctrl.load_index) == IDX)) begin
            pat_reg <= word;
        end
    end

    // prefix extends when the neighbor's prefix held and this word matches
    assign hit       = (pat_reg == word);
    assign flag_next = flag_in & hit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flag_reg <= 1'b0;
        end else if (ctrl.text_en) begin
            flag_reg <= ctrl.clear ? 1'b0 : flag_next;
        end
    end

    assign flag_out = flag_reg;

endmodule

// File: sv/soc_counter.sv
// soc_counter: saturating occurrence count for the current stream;
// depends on soc_pkg
module soc_counter #(
    parameter int MAX_COUNT = soc_pkg::DEF_MAX_COUNT,
    localparam int CNT_W = (MAX_COUNT > 1) ? $clog2(MAX_COUNT + 1) : 1
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  soc_pkg::soc_ctrl_t ctrl,
    input  logic             match,
    output logic [CNT_W-1:0] count_next,
    output logic [CNT_W-1:0] count_value
);
    import soc_pkg::*;

    logic [CNT_W-1:0] count_reg;

    // count this match unless already at the bound
    always_comb begin
        count_next = count_reg;
        if (match && (count_reg < CNT_W'(MAX_COUNT))) begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    // end of stream restarts the count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (ctrl.text_en) begin
            count_reg <= ctrl.clear ? '0 : count_next;
        end
    end

    assign count_value = count_reg;

endmodule
